### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DELETED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Empty-queue return value: all ones.
  localparam data_t EMPTY_VALUE = '1;

  typedef struct packed {
    data_t key;
    data_t pri;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic   shift_in;   // insert into a non-full queue accepted
    logic   shift_out;  // delete of a non-empty queue accepted
    entry_t new_entry;
  } cell_cmd_t;

endpackage

### hw/rtl/spq_in_if.sv
// Input channel: operation, key and priority with valid/ready.
interface spq_in_if;
  logic                valid;
  logic                ready;
  spq_pkg::op_t        operation;
  spq_pkg::data_t      key;
  spq_pkg::data_t      priority_req;

  modport source (output valid, output operation, output key, output priority_req,
                  input ready);
  modport sink   (input valid, input operation, input key, input priority_req,
                  output ready);
endinterface

### hw/rtl/spq_out_if.sv
// Result channel: status, key and priority with valid/ready.
interface spq_out_if;
  logic                valid;
  logic                ready;
  spq_pkg::status_t    status;
  spq_pkg::data_t      out_key;
  spq_pkg::data_t      out_priority;

  modport source (output valid, output status, output out_key, output out_priority,
                  input ready);
  modport sink   (input valid, input status, input out_key, input out_priority,
                  output ready);
endinterface

### hw/rtl/spq_cell.sv
// One slot of the sorted row: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               prev_after,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               after,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // New entry goes behind this one when this one has equal or smaller priority.
  assign after = occupied && (entry_r.pri <= cmd.new_entry.pri);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift_in) begin
      if (!after) begin
        // First cell not ahead of the new entry takes it; the rest move down.
        entry_nxt = prev_after ? cmd.new_entry : prev_entry;
      end
    end else if (cmd.shift_out) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue top level: a row of cells, an entry count and a result register.
// The queue takes one insert or delete per clock cycle, and its result appears in the
// output register on the next cycle; the input stalls only while a result waits unread.
// All cells update together in the accepting cycle: on insert every cell compares its
// priority with the new one (signed) and either holds, takes the new entry, or takes its
// upper neighbor's entry; on delete every cell takes its lower neighbor's entry and the
// front cell's entry is returned. Equal priorities leave first in, first out. An insert
// into a full queue returns status full and changes nothing; a delete from an empty
// queue returns status empty with key and priority all ones. No clearing pass follows
// reset: the queue is usable in the first cycle after rst_n rises.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_if,
  spq_out_if.source  out_if
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  spq_pkg::status_t   status_r;
  spq_pkg::data_t     key_r;
  spq_pkg::data_t     pri_r;

  logic               accept;
  logic               is_insert;
  logic               full;
  logic               empty;
  spq_pkg::cell_cmd_t cmd;

  spq_pkg::entry_t    entries [CAPACITY];
  logic               afters  [CAPACITY];

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_insert   = (in_if.operation == spq_pkg::OP_INSERT);
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign empty       = (count_r == '0);

  assign cmd.shift_in      = accept && is_insert && !full;
  assign cmd.shift_out     = accept && !is_insert && !empty;
  assign cmd.new_entry.key = in_if.key;
  assign cmd.new_entry.pri = in_if.priority_req;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            occ;
    logic            prev_after;
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_front
      assign prev_after = 1'b1;
      assign prev_entry = cmd.new_entry;
    end else begin : g_mid
      assign prev_after = afters[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign next_entry = entries[i];
    end else begin : g_body
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ),
      .prev_after (prev_after),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .after      (afters[i]),
      .entry      (entries[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.shift_in) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.shift_out) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; load on each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_insert) begin
        status_r <= full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
        key_r    <= '0;
        pri_r    <= '0;
      end else if (empty) begin
        status_r <= spq_pkg::ST_EMPTY;
        key_r    <= spq_pkg::EMPTY_VALUE;
        pri_r    <= spq_pkg::EMPTY_VALUE;
      end else begin
        status_r <= spq_pkg::ST_DELETED;
        key_r    <= entries[0].key;
        pri_r    <= entries[0].pri;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = status_r;
  assign out_if.out_key      = key_r;
  assign out_if.out_priority = pri_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_insert: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_in |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count did not advance on insert");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_insert && full) |=> status_r == spq_pkg::ST_FULL && count_r == $past(count_r))
    else $error("full insert not rejected");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == spq_pkg::ST_EMPTY) |->
      (key_r == spq_pkg::EMPTY_VALUE && pri_r == spq_pkg::EMPTY_VALUE))
    else $error("empty result carries data");

  a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> entries[0].pri <= entries[1].pri)
    else $error("front entries out of order");
`endif

endmodule

### tb/spq_checker.sv
// Checker for the sorted priority queue: predicts each result beat and compares it.
`timescale 1ns / 100ps

module spq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  spq_in_if    in_mon,
  spq_out_if   out_mon,
  output int   mismatches,
  output int   owed
);

  typedef struct {
    spq_pkg::status_t status;
    spq_pkg::data_t   key;
    spq_pkg::data_t   pri;
  } queue_reply_t;

  // Predicted queue contents in service order, front at index 0.
  spq_pkg::entry_t held_entries[$];
  queue_reply_t    owed_replies[$];

  function automatic queue_reply_t serve_queue_op(spq_pkg::op_t op, spq_pkg::data_t key,
                                                  spq_pkg::data_t pri);
    queue_reply_t r;
    int           slot;
    r.status = spq_pkg::ST_INSERTED;
    r.key    = '0;
    r.pri    = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_entries.size() >= CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // Land behind every entry of equal or smaller priority.
        slot = 0;
        while (slot < held_entries.size() &&
               $signed(held_entries[slot].pri) <= $signed(pri))
          slot++;
        held_entries.insert(slot, '{key: key, pri: pri});
      end
    end else if (held_entries.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
      r.key    = spq_pkg::EMPTY_VALUE;
      r.pri    = spq_pkg::EMPTY_VALUE;
    end else begin
      r.status = spq_pkg::ST_DELETED;
      r.key    = held_entries[0].key;
      r.pri    = held_entries[0].pri;
      void'(held_entries.pop_front());
    end
    return r;
  endfunction

  always @(posedge clk) begin
    queue_reply_t due;
    if (!rst_n) begin
      held_entries.delete();
      owed_replies.delete();
      mismatches = 0;
    end else begin
      // Retire the result beat first: it always belongs to an earlier item.
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (owed_replies.size() == 0) begin
          $error("result beat with no item outstanding: status %0d key %0d priority %0d",
                 out_mon.status, out_mon.out_key, out_mon.out_priority);
          mismatches++;
        end else begin
          due = owed_replies.pop_front();
          if (out_mon.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_mon.status);
            mismatches++;
          end
          if (out_mon.out_key !== due.key) begin
            $error("out_key: expected %0d, got %0d", due.key, out_mon.out_key);
            mismatches++;
          end
          if (out_mon.out_priority !== due.pri) begin
            $error("out_priority: expected %0d, got %0d", due.pri, out_mon.out_priority);
            mismatches++;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        owed_replies.push_back(serve_queue_op(in_mon.operation, in_mon.key,
                                              in_mon.priority_req));
    end
    owed = owed_replies.size();
  end

endmodule

### tb/sorted_priority_queue_tb.sv
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

  localparam int unsigned    QUEUE_DEPTH = 16;
  localparam int             LONG_HOLD   = 80;
  localparam int             SEGMENTS    = 14;
  localparam int             SEG_ITEMS   = 64;
  localparam spq_pkg::data_t MIN_VAL     = 32'sh8000_0000;
  localparam spq_pkg::data_t MAX_VAL     = 32'sh7FFF_FFFF;

  logic clk;
  logic rst_n;
  int   fails;
  int   owed;
  bit   src_idle_on;
  bit   sink_idle_on;
  bit   hold_sink;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(.CAPACITY(QUEUE_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  spq_checker #(.CAPACITY(QUEUE_DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (fails),
    .owed       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stalls, plus one long hold on request.
  initial begin : sink_side
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_sink = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(spq_pkg::op_t op, spq_pkg::data_t key, spq_pkg::data_t pri);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= spq_pkg::op_t'($urandom_range(0, 1));
        in_ch.key          <= $urandom;
        in_ch.priority_req <= $urandom;
      end
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.key          <= key;
    in_ch.priority_req <= pri;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Hold the input quiet until every outstanding result has come back.
  task automatic wait_all_returned();
    do begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end while (owed != 0);
  endtask

  function automatic spq_pkg::data_t pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return spq_pkg::data_t'(int'($urandom_range(0, 7)) - 4);
      5, 6, 7:       return spq_pkg::data_t'($urandom);
      8:             return MIN_VAL;
      default:       return MAX_VAL;
    endcase
  endfunction

  initial begin : stimulus
    spq_pkg::data_t dir_pri [16];
    spq_pkg::data_t key;
    spq_pkg::op_t   op;
    int             ins_odds;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = spq_pkg::OP_INSERT;
    in_ch.key          = '0;
    in_ch.priority_req = '0;
    src_idle_on        = 1'b1;
    sink_idle_on       = 1'b1;
    hold_sink          = 1'b0;
    dir_pri = '{MIN_VAL, MAX_VAL, 0, -1, 1, 5, 5, 5,
                MIN_VAL, MAX_VAL, -1, 0, 5, 32'sh4000_0000, 32'shBFFF_FFFF, 5};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Delete from empty, fill with extremes and ties, overflow, then partly drain.
    send_item(spq_pkg::OP_DELETE, spq_pkg::data_t'($urandom), spq_pkg::data_t'($urandom));
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:       key = MAX_VAL;
        1:       key = MIN_VAL;
        2:       key = '0;
        3:       key = '1;
        default: key = spq_pkg::data_t'($urandom);
      endcase
      send_item(spq_pkg::OP_INSERT, key, dir_pri[i]);
    end
    send_item(spq_pkg::OP_INSERT, spq_pkg::data_t'($urandom), MIN_VAL);
    repeat (5) send_item(spq_pkg::OP_DELETE, spq_pkg::data_t'($urandom),
                         spq_pkg::data_t'($urandom));

    // Random part: segments lean toward filling, draining or an even mix.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS - 1) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      if (seg == 4)
        hold_sink = 1'b1;
      if (seg == 8)
        wait_all_returned();
      if (seg == 6 || seg == 10)
        src_idle_on = 1'b0;
      if (seg == 7 || seg == 11)
        src_idle_on = 1'b1;
      case (seg % 3)
        0:       ins_odds = 8;
        1:       ins_odds = 2;
        default: ins_odds = 5;
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        op = ($urandom_range(0, 9) < ins_odds) ? spq_pkg::OP_INSERT : spq_pkg::OP_DELETE;
        send_item(op, spq_pkg::data_t'($urandom), pick_priority());
      end
    end

    wait_all_returned();
    repeat (10) @(negedge clk);
    if (fails == 0 && owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
